// ----- rtl/core/pvfe_pkg.sv -----
// pvfe_pkg: widths, payload structs and back-end state codes of the peak and valley
// feature extractor; depends on nothing, used by every file under rtl/core
package pvfe_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int INDEX_W    = 16;
  localparam int SLOPE_FRAC = 8;
  localparam int SLOPE_W    = SAMPLE_W + SLOPE_FRAC;

  // one input item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } pvfe_in_t;

  // one result item
  typedef struct packed {
    logic [INDEX_W-1:0]         peak_position;
    logic signed [SAMPLE_W-1:0] peak_level;
    logic [SAMPLE_W-1:0]        height_max;
    logic [SAMPLE_W:0]          height_sum;
    logic [SLOPE_W-1:0]         slope_max;
    logic [SLOPE_W:0]           slope_sum;
    logic [INDEX_W-1:0]         spread_left;
    logic [INDEX_W-1:0]         spread_right;
    logic                       closed_by_end;
  } pvfe_out_t;

  // a closed peak, handed from the front end to the back end
  typedef struct packed {
    logic [INDEX_W-1:0]         peak_pos;
    logic signed [SAMPLE_W-1:0] peak_lvl;
    logic [INDEX_W-1:0]         left_pos;
    logic signed [SAMPLE_W-1:0] left_lvl;
    logic [INDEX_W-1:0]         right_pos;
    logic signed [SAMPLE_W-1:0] right_lvl;
    logic                       by_end;
  } pvfe_evt_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_START_L,
    BK_WAIT_L,
    BK_START_R,
    BK_WAIT_R,
    BK_EMIT
  } pvfe_back_state_t;

endpackage

// ----- rtl/core/pvfe_front.sv -----
// pvfe_front: slope tracking, valley and peak marking, closed-peak detection
// depends on pvfe_pkg; pushes closed peaks into pvfe_queue
module pvfe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pvfe_pkg::pvfe_in_t  in_data,
  input  logic                q_full,
  output logic                q_push,
  output pvfe_pkg::pvfe_evt_t q_data
);

  localparam logic [pvfe_pkg::INDEX_W-1:0] IMAX = '1;

  logic signed [pvfe_pkg::SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                                 have_prev_r, have_prev_nxt;
  logic                                 started_r, started_nxt;
  logic                                 rising_r, rising_nxt;
  logic [pvfe_pkg::INDEX_W-1:0]         pos_r, pos_nxt;
  logic [pvfe_pkg::INDEX_W-1:0]         valley_pos_r, valley_pos_nxt;
  logic signed [pvfe_pkg::SAMPLE_W-1:0] valley_lvl_r, valley_lvl_nxt;
  logic                                 pend_r, pend_nxt;
  logic [pvfe_pkg::INDEX_W-1:0]         pend_pos_r, pend_pos_nxt;
  logic signed [pvfe_pkg::SAMPLE_W-1:0] pend_lvl_r, pend_lvl_nxt;

  logic                                 accept;
  logic                                 falling;
  logic                                 emit_mid;
  logic                                 emit_end;
  logic [pvfe_pkg::INDEX_W-1:0]         idx;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign falling  = in_data.sample < prev_r;

  always_comb begin
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    started_nxt    = started_r;
    rising_nxt     = rising_r;
    pos_nxt        = pos_r;
    valley_pos_nxt = valley_pos_r;
    valley_lvl_nxt = valley_lvl_r;
    pend_nxt       = pend_r;
    pend_pos_nxt   = pend_pos_r;
    pend_lvl_nxt   = pend_lvl_r;
    emit_mid       = 1'b0;
    idx            = '0;

    if (have_prev_r) begin
      // index saturates at its top value
      idx = (pos_r != IMAX) ? pos_r + 1'b1 : pos_r;
      if (!started_r) begin
        if (!falling) begin
          valley_pos_nxt = pos_r;
          valley_lvl_nxt = prev_r;
          started_nxt    = 1'b1;
          rising_nxt     = 1'b1;
        end
      end else if (falling) begin
        if (rising_r) begin
          pend_nxt     = 1'b1;
          pend_pos_nxt = pos_r;
          pend_lvl_nxt = prev_r;
          rising_nxt   = 1'b0;
        end
      end else begin
        if (!rising_r) begin
          emit_mid       = pend_r;
          valley_pos_nxt = pos_r;
          valley_lvl_nxt = prev_r;
          pend_nxt       = 1'b0;
        end
        rising_nxt = 1'b1;
      end
    end

    emit_end = in_data.last && started_nxt && !rising_nxt && pend_nxt && !emit_mid;

    q_data.peak_pos  = pend_pos_nxt;
    q_data.peak_lvl  = pend_lvl_nxt;
    q_data.left_pos  = valley_pos_r;
    q_data.left_lvl  = valley_lvl_r;
    q_data.right_pos = emit_mid ? pos_r : idx;
    q_data.right_lvl = emit_mid ? prev_r : in_data.sample;
    q_data.by_end    = !emit_mid;

    if (in_data.last) begin
      // end of signal: back to the reset state
      prev_nxt       = '0;
      have_prev_nxt  = 1'b0;
      started_nxt    = 1'b0;
      rising_nxt     = 1'b1;
      pos_nxt        = '0;
      valley_pos_nxt = '0;
      valley_lvl_nxt = '0;
      pend_nxt       = 1'b0;
      pend_pos_nxt   = '0;
      pend_lvl_nxt   = '0;
    end else begin
      prev_nxt      = in_data.sample;
      have_prev_nxt = 1'b1;
      pos_nxt       = idx;
    end
  end

  assign q_push = accept && (emit_mid || emit_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= '0;
      have_prev_r  <= 1'b0;
      started_r    <= 1'b0;
      rising_r     <= 1'b1;
      pos_r        <= '0;
      valley_pos_r <= '0;
      valley_lvl_r <= '0;
      pend_r       <= 1'b0;
      pend_pos_r   <= '0;
      pend_lvl_r   <= '0;
    end else if (accept) begin
      prev_r       <= prev_nxt;
      have_prev_r  <= have_prev_nxt;
      started_r    <= started_nxt;
      rising_r     <= rising_nxt;
      pos_r        <= pos_nxt;
      valley_pos_r <= valley_pos_nxt;
      valley_lvl_r <= valley_lvl_nxt;
      pend_r       <= pend_nxt;
      pend_pos_r   <= pend_pos_nxt;
      pend_lvl_r   <= pend_lvl_nxt;
    end
  end

endmodule

// ----- rtl/core/pvfe_queue.sv -----
// pvfe_queue: small register queue of closed peaks between front and back end
// depends on pvfe_pkg for the peak record type
module pvfe_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pvfe_pkg::pvfe_evt_t push_data,
  output logic                full,
  input  logic                pop,
  output pvfe_pkg::pvfe_evt_t pop_data,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pvfe_pkg::pvfe_evt_t mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/pvfe_div.sv -----
// pvfe_div: restoring divider, one quotient bit per cycle, for the slope terms
// depends on pvfe_pkg for operand widths
module pvfe_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pvfe_pkg::SLOPE_W-1:0]  dividend,
  input  logic [pvfe_pkg::INDEX_W-1:0]  divisor,
  output logic                          done,
  output logic [pvfe_pkg::SLOPE_W-1:0]  quotient
);

  localparam int DVD_W = pvfe_pkg::SLOPE_W;
  localparam int DEN_W = pvfe_pkg::INDEX_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign shifted  = {rem_r, q_r[DVD_W-1]};
  assign diff     = shifted - {1'b0, den_r};
  assign fits     = shifted >= {1'b0, den_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out at the top, quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

endmodule

// ----- rtl/core/pvfe_back.sv -----
// pvfe_back: heights, spreads and slopes of one closed peak, with result register
// depends on pvfe_pkg and pvfe_div
module pvfe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  pvfe_pkg::pvfe_evt_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output pvfe_pkg::pvfe_out_t out_data
);

  localparam int SW = pvfe_pkg::SAMPLE_W;
  localparam int IW = pvfe_pkg::INDEX_W;
  localparam int LW = pvfe_pkg::SLOPE_W;

  function automatic logic [SW-1:0] abs_diff(logic signed [SW-1:0] a, logic signed [SW-1:0] b);
    logic [SW:0] d;
    d = {a[SW-1], a} - {b[SW-1], b};
    abs_diff = d[SW] ? SW'(~d + 1'b1) : d[SW-1:0];
  endfunction

  pvfe_pkg::pvfe_back_state_t state_r, state_nxt;

  pvfe_pkg::pvfe_evt_t ev_r;
  logic [SW-1:0]       hl_r, hr_r;
  logic [IW-1:0]       spl_r, spr_r;
  logic [LW-1:0]       sl_r, sr_r;
  logic                out_valid_r;
  pvfe_pkg::pvfe_out_t out_data_r;

  logic                div_start;
  logic                div_done;
  logic [LW-1:0]       div_q;
  logic [SW-1:0]       h_sel;
  logic [IW-1:0]       s_sel;
  logic [IW-1:0]       divisor;
  logic                load_out;
  pvfe_pkg::pvfe_out_t res;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pvfe_pkg::BK_IDLE:    if (!q_empty) state_nxt = pvfe_pkg::BK_PREP;
      pvfe_pkg::BK_PREP:    state_nxt = pvfe_pkg::BK_START_L;
      pvfe_pkg::BK_START_L: state_nxt = pvfe_pkg::BK_WAIT_L;
      pvfe_pkg::BK_WAIT_L:  if (div_done) state_nxt = pvfe_pkg::BK_START_R;
      pvfe_pkg::BK_START_R: state_nxt = pvfe_pkg::BK_WAIT_R;
      pvfe_pkg::BK_WAIT_R:  if (div_done) state_nxt = pvfe_pkg::BK_EMIT;
      pvfe_pkg::BK_EMIT:    if (!out_valid_r || out_ready) state_nxt = pvfe_pkg::BK_IDLE;
      default:              state_nxt = pvfe_pkg::BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      pvfe_pkg::BK_IDLE:    q_pop     = !q_empty;
      pvfe_pkg::BK_START_L: div_start = 1'b1;
      pvfe_pkg::BK_START_R: div_start = 1'b1;
      pvfe_pkg::BK_EMIT:    load_out  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // a zero spread (saturated index) divides as if it were one
  assign h_sel   = (state_r == pvfe_pkg::BK_START_R) ? hr_r : hl_r;
  assign s_sel   = (state_r == pvfe_pkg::BK_START_R) ? spr_r : spl_r;
  assign divisor = (s_sel == '0) ? IW'(1) : s_sel;

  pvfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (LW'({h_sel, {pvfe_pkg::SLOPE_FRAC{1'b0}}})),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    res.peak_position = ev_r.peak_pos;
    res.peak_level    = ev_r.peak_lvl;
    res.height_max    = (hl_r > hr_r) ? hl_r : hr_r;
    res.height_sum    = {1'b0, hl_r} + {1'b0, hr_r};
    res.slope_max     = (sl_r > sr_r) ? sl_r : sr_r;
    res.slope_sum     = {1'b0, sl_r} + {1'b0, sr_r};
    res.spread_left   = spl_r;
    res.spread_right  = spr_r;
    res.closed_by_end = ev_r.by_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pvfe_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ev_r <= q_data;
    end
    if (state_r == pvfe_pkg::BK_PREP) begin
      hl_r  <= abs_diff(ev_r.peak_lvl, ev_r.left_lvl);
      hr_r  <= abs_diff(ev_r.peak_lvl, ev_r.right_lvl);
      spl_r <= ev_r.peak_pos - ev_r.left_pos;
      spr_r <= ev_r.right_pos - ev_r.peak_pos;
    end
    if (state_r == pvfe_pkg::BK_WAIT_L && div_done) begin
      sl_r <= div_q;
    end
    if (state_r == pvfe_pkg::BK_WAIT_R && div_done) begin
      sr_r <= div_q;
    end
    if (load_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/peak_valley_feature_extractor.sv -----
// peak_valley_feature_extractor: top level, front end, peak queue and back end
// depends on pvfe_pkg, pvfe_front, pvfe_queue, pvfe_back (and pvfe_div below it)
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready    pvfe_in_t  (sample, last)
//   out_     output     out_valid/out_ready  pvfe_out_t (one result per closed peak)
//
// the front end takes one sample a cycle while the peak queue has room; a sample
//   that closes a peak writes one record into the queue
// the back end runs the two slope divisions of a peak in turn on the one bit-serial
//   divider, and pops the next peak only once the last result is loaded
// a peak takes at least two samples
// rst_n is synchronous: all tracking state, the queue and the result flag clear at once
// a stalled out_ready holds the result register; in_ready drops only when the queue fills
module peak_valley_feature_extractor #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pvfe_pkg::pvfe_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pvfe_pkg::pvfe_out_t out_data
);

  // closed-peak records between the two halves
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  pvfe_pkg::pvfe_evt_t q_wdata;
  pvfe_pkg::pvfe_evt_t q_rdata;

  // slope tracking and peak/valley marking
  pvfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // lets sampling run on while the divider is busy
  pvfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // heights, spreads, slopes and the result register
  pvfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
